/* sv/kvlm_pkg.sv */
package kvlm_pkg;

    localparam int VALUE_DEPTH = 64;
    localparam int KEY_BYTES   = 8;
    localparam int VAL_AW      = $clog2(VALUE_DEPTH);

    typedef logic [7:0]        char_t;
    typedef logic [VAL_AW-1:0] vidx_t;

    // characters
    localparam char_t CH_TAB    = 8'h09;
    localparam char_t CH_LF     = 8'h0A;
    localparam char_t CH_CR     = 8'h0D;
    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_DQUOTE = 8'h22;
    localparam char_t CH_SQUOTE = 8'h27;
    localparam char_t CH_COLON  = 8'h3A;
    localparam char_t CH_EQUAL  = 8'h3D;
    localparam char_t CH_BSLASH = 8'h5C;

    // line status codes
    localparam logic [1:0] STATUS_NO_MATCH = 2'd0;
    localparam logic [1:0] STATUS_FOUND    = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_KEY_TEXT   = 3'd0;
    localparam logic [2:0] REG_KEY_LENGTH = 3'd1;
    localparam logic [2:0] REG_CAPACITY   = 3'd2;
    localparam logic [2:0] REG_BLANK_SKIP = 3'd3;
    localparam logic [2:0] REG_QUOTING    = 3'd4;

    // open quote codes
    localparam logic [1:0] Q_NONE   = 2'd0;
    localparam logic [1:0] Q_SINGLE = 2'd1;
    localparam logic [1:0] Q_DOUBLE = 2'd2;

endpackage

/* sv/key_value_line_matcher.sv */
// Channel  | Direction | Handshake                  | Payload
// byte     | in        | byte_valid / byte_ready    | data_byte, end_of_stream
// result   | out       | result_valid / result_ready| line_status, value_byte,
//          |           |                            | value_length, last_of_run
// config   | in        | cfg_wen (no wait)          | cfg_addr, cfg_wdata
//
// Ordinary bytes are taken at one per cycle while no buffer walk runs.
// A line end with a value of n characters walks the value buffer RAM at one
// result per cycle when results are taken; bytes wait until the walk ends.
// A line end with a single status result is taken only when the output
// register is free. The output register lets bytes flow while a result waits.
// rst_n clears line state and loads the register reset values; the value RAM
// is not cleared, only entries written on the current line are read.
module key_value_line_matcher
    import kvlm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,

    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  line_status,
    output logic [7:0]  value_byte,
    output logic [5:0]  value_length,
    output logic        last_of_run,

    input  logic        cfg_wen,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata
);

    localparam logic ST_IN   = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    localparam logic [3:0] PH_START   = 4'd0;
    localparam logic [3:0] PH_LEAD    = 4'd1;
    localparam logic [3:0] PH_KEY     = 4'd2;
    localparam logic [3:0] PH_AFTER   = 4'd3;
    localparam logic [3:0] PH_VLEAD   = 4'd4;
    localparam logic [3:0] PH_VALUE   = 4'd5;
    localparam logic [3:0] PH_DONE    = 4'd6;
    localparam logic [3:0] PH_NOMATCH = 4'd7;
    localparam logic [3:0] PH_LONG    = 4'd8;

    // configuration
    logic [63:0] key_text_reg;
    logic [3:0]  key_length_reg;
    logic [6:0]  capacity_reg;
    logic        blank_en_reg;
    logic        quote_en_reg;

    // line state
    logic        state_reg,   state_next;
    logic [3:0]  phase_reg,   phase_next;
    logic [3:0]  key_pos_reg, key_pos_next;
    vidx_t       count_reg,   count_next;
    vidx_t       nb_len_reg,  nb_len_next;   // length up to last non-blank
    logic [1:0]  quote_reg,   quote_next;
    logic        bs_reg,      bs_next;

    // emission
    vidx_t       k_reg,       k_next;
    vidx_t       n_reg,       n_next;
    logic [1:0]  st_reg,      st_next;
    logic        rd_pend_reg, rd_pend_next;

    // output register
    logic        rv_reg,      rv_next;
    logic [1:0]  ostat_reg,   ostat_next;
    char_t       obyte_reg,   obyte_next;
    vidx_t       olen_reg,    olen_next;
    logic        olast_reg,   olast_next;

    // RAM
    logic        ram_we;
    vidx_t       ram_wa;
    char_t       ram_wd;
    logic        ram_re;
    char_t       ram_rd;

    // combinational helpers
    logic        byte_acc;
    logic        term;
    logic        blank;
    logic        skip;
    logic [3:0]  eff_len;
    logic [6:0]  limit;
    logic        do_match;
    logic [3:0]  match_pos;
    char_t       key_char;
    logic        do_value;
    char_t       qc;
    logic [6:0]  count_inc;
    logic [1:0]  end_st;
    vidx_t       end_n;
    logic        issue;
    logic        load_now;

    assign skip  = blank_en_reg;
    assign term  = end_of_stream || (data_byte == CH_LF);
    assign blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB);

    assign byte_ready = (state_reg == ST_IN) && (!term || !rv_reg || result_ready);
    assign byte_acc   = byte_valid && byte_ready;

    always_comb
    begin
        if (key_length_reg == 4'd0)
            eff_len = 4'd1;
        else if (key_length_reg > 4'(KEY_BYTES))
            eff_len = 4'(KEY_BYTES);
        else
            eff_len = key_length_reg;

        if (capacity_reg < 7'd2)
            limit = 7'd1;
        else if (capacity_reg > 7'(VALUE_DEPTH))
            limit = 7'(VALUE_DEPTH - 1);
        else
            limit = capacity_reg - 7'd1;
    end

    assign load_now = (state_reg == ST_EMIT) && rd_pend_reg && (!rv_reg || result_ready);
    assign issue    = (state_reg == ST_EMIT) && (k_reg != n_reg)
                      && (!rd_pend_reg || load_now);

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        key_pos_next = key_pos_reg;
        count_next   = count_reg;
        nb_len_next  = nb_len_reg;
        quote_next   = quote_reg;
        bs_next      = bs_reg;
        k_next       = k_reg;
        n_next       = n_reg;
        st_next      = st_reg;
        rd_pend_next = rd_pend_reg;
        rv_next      = rv_reg;
        ostat_next   = ostat_reg;
        obyte_next   = obyte_reg;
        olen_next    = olen_reg;
        olast_next   = olast_reg;
        ram_we       = 1'b0;
        ram_wa       = count_reg;
        ram_wd       = data_byte;
        ram_re       = issue;
        do_match     = 1'b0;
        match_pos    = key_pos_reg;
        do_value     = 1'b0;
        key_char     = 8'h00;
        qc           = (quote_reg == Q_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
        count_inc    = {1'b0, count_reg} + 7'd1;
        end_st       = STATUS_NO_MATCH;
        end_n        = '0;

        if (result_ready)
            rv_next = 1'b0;

        if (byte_acc && !term)
        begin
            unique case (phase_reg)
                PH_START, PH_LEAD:
                begin
                    if (skip && blank)
                    begin
                        phase_next = PH_LEAD;
                    end
                    else
                    begin
                        do_match  = 1'b1;
                        match_pos = 4'd0;
                    end
                end
                PH_KEY:
                begin
                    do_match = 1'b1;
                end
                PH_AFTER:
                begin
                    if (!(skip && blank))
                    begin
                        if (data_byte == CH_EQUAL || data_byte == CH_COLON)
                        begin
                            count_next  = '0;
                            nb_len_next = '0;
                            quote_next  = Q_NONE;
                            bs_next     = 1'b0;
                            phase_next  = skip ? PH_VLEAD : PH_VALUE;
                        end
                        else
                        begin
                            phase_next = PH_NOMATCH;
                        end
                    end
                end
                PH_VLEAD:
                begin
                    do_value = !(skip && blank);
                end
                PH_VALUE:
                begin
                    do_value = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (do_match)
            begin
                key_char = key_text_reg[{match_pos[2:0], 3'b000} +: 8];
                if (data_byte == key_char && match_pos < 4'(KEY_BYTES))
                begin
                    key_pos_next = match_pos + 4'd1;
                    phase_next   = ((match_pos + 4'd1) >= eff_len) ? PH_AFTER : PH_KEY;
                end
                else
                begin
                    key_pos_next = match_pos;
                    phase_next   = PH_NOMATCH;
                end
            end

            if (do_value)
            begin
                phase_next = PH_VALUE;
                if (data_byte == CH_CR)
                begin
                    count_next = skip ? nb_len_reg : count_reg;
                    phase_next = PH_DONE;
                end
                else if (quote_en_reg && quote_reg == Q_NONE
                         && (data_byte == CH_SQUOTE || data_byte == CH_DQUOTE))
                begin
                    quote_next = (data_byte == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
                end
                else if (quote_en_reg && quote_reg != Q_NONE && data_byte == qc && !bs_reg)
                begin
                    phase_next = PH_DONE;
                end
                else if (quote_en_reg && quote_reg != Q_NONE && data_byte == qc)
                begin
                    // escaped quote replaces the backslash already stored
                    ram_we  = (count_reg != '0);
                    ram_wa  = count_reg - vidx_t'(1);
                    bs_next = 1'b0;
                end
                else
                begin
                    bs_next    = (data_byte == CH_BSLASH);
                    ram_we     = 1'b1;
                    count_next = count_inc[VAL_AW-1:0];
                    if (!blank)
                        nb_len_next = count_inc[VAL_AW-1:0];
                    if (count_inc >= limit)
                        phase_next = PH_LONG;
                end
            end
        end

        if (byte_acc && term)
        begin
            unique case (phase_reg)
                PH_VLEAD, PH_VALUE:
                begin
                    end_st = STATUS_FOUND;
                    end_n  = skip ? nb_len_reg : count_reg;
                end
                PH_DONE:
                begin
                    end_st = STATUS_FOUND;
                    end_n  = count_reg;
                end
                PH_LONG:
                begin
                    end_st = STATUS_TOO_LONG;
                end
                default:
                begin
                    end_st = STATUS_NO_MATCH;
                end
            endcase

            if (!(end_of_stream && phase_reg == PH_START))
            begin
                if (end_n == '0)
                begin
                    rv_next    = 1'b1;
                    ostat_next = end_st;
                    obyte_next = 8'h00;
                    olen_next  = '0;
                    olast_next = 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                    st_next    = end_st;
                    n_next     = end_n;
                    k_next     = '0;
                end
            end

            phase_next   = PH_START;
            key_pos_next = 4'd0;
            count_next   = '0;
            nb_len_next  = '0;
            quote_next   = Q_NONE;
            bs_next      = 1'b0;
        end

        // buffer walk: data for index k-1 sits in the RAM read register
        if (issue)
            k_next = k_reg + vidx_t'(1);
        rd_pend_next = issue || (rd_pend_reg && !load_now);

        if (load_now)
        begin
            rv_next    = 1'b1;
            ostat_next = st_reg;
            obyte_next = ram_rd;
            olen_next  = n_reg;
            olast_next = (k_reg == n_reg);
            if (k_reg == n_reg)
                state_next = ST_IN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_text_reg   <= 64'd0;
            key_length_reg <= 4'd1;
            capacity_reg   <= 7'd64;
            blank_en_reg   <= 1'b1;
            quote_en_reg   <= 1'b1;
            state_reg      <= ST_IN;
            phase_reg      <= PH_START;
            key_pos_reg    <= 4'd0;
            count_reg      <= '0;
            nb_len_reg     <= '0;
            quote_reg      <= Q_NONE;
            bs_reg         <= 1'b0;
            k_reg          <= '0;
            rd_pend_reg    <= 1'b0;
            rv_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_addr)
                    REG_KEY_TEXT:   key_text_reg   <= cfg_wdata;
                    REG_KEY_LENGTH: key_length_reg <= cfg_wdata[3:0];
                    REG_CAPACITY:   capacity_reg   <= cfg_wdata[6:0];
                    REG_BLANK_SKIP: blank_en_reg   <= cfg_wdata[0];
                    REG_QUOTING:    quote_en_reg   <= cfg_wdata[0];
                    default:
                    begin
                    end
                endcase
            end
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            key_pos_reg <= key_pos_next;
            count_reg   <= count_next;
            nb_len_reg  <= nb_len_next;
            quote_reg   <= quote_next;
            bs_reg      <= bs_next;
            k_reg       <= k_next;
            rd_pend_reg <= rd_pend_next;
            rv_reg      <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        st_reg    <= st_next;
        ostat_reg <= ostat_next;
        obyte_reg <= obyte_next;
        olen_reg  <= olen_next;
        olast_reg <= olast_next;
    end

    kvlm_ram #(
        .WIDTH (8),
        .DEPTH (VALUE_DEPTH)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (ram_re),
        .rd_addr (k_reg),
        .rd_data (ram_rd)
    );

    assign result_valid = rv_reg;
    assign line_status  = ostat_reg;
    assign value_byte   = obyte_reg;
    assign value_length = olen_reg;
    assign last_of_run  = olast_reg;

`ifndef SYNTH
    a_nb_within_count: assert property (@(posedge clk) disable iff (!rst_n)
        nb_len_reg <= count_reg)
        else $error("trim length beyond value count");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (k_reg <= n_reg))
        else $error("buffer walk past value length");

    a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_pend_reg && !load_now) |=> $stable(ram_rd))
        else $error("pending read data lost");

    a_walk_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (load_now && k_reg == n_reg) |=> (state_reg == ST_IN && !rd_pend_reg))
        else $error("walk did not finish after last result");
`endif

endmodule

/* sv/kvlm_ram.sv */
module kvlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
